### design/rce_pkg.sv
// Shared types, constants and calendar tables for the RTC to epoch-seconds converter.
package rce_pkg;

  localparam int unsigned NumStages = 6;

  typedef struct packed {
    logic [NumStages-1:0] vld;
    logic [NumStages-1:0] en;
  } pipe_ctl_t;

  // Reciprocal multipliers for exact division of narrow values by constants.
  localparam int unsigned Div60Mul   = 137;
  localparam int unsigned Div60Shift = 13;
  localparam int unsigned Div12Mul   = 171;
  localparam int unsigned Div12Shift = 11;
  localparam int unsigned Div24Mul   = 171;
  localparam int unsigned Div24Shift = 12;
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;

  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned MinPerHour = 60;
  localparam int unsigned HourPerDay = 24;
  localparam int unsigned MonPerYear = 12;
  localparam int unsigned SecPerHour = 3600;
  localparam int unsigned SecPerDay  = 86400;
  localparam int unsigned DayPerYear = 365;
  localparam int unsigned YearsPerCentury = 100;
  localparam int unsigned EpochYear  = 1970;
  localparam int unsigned BaseYear   = 1900;
  localparam int unsigned LeapDayFeb = 29;
  localparam logic [3:0]  MonFeb     = 4'd1;
  localparam logic [37:0] EpochMax   = '1;

  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] mon);
    logic [8:0] start;
    unique case (mon)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd59;
      4'd3:    start = 9'd90;
      4'd4:    start = 9'd120;
      4'd5:    start = 9'd151;
      4'd6:    start = 9'd181;
      4'd7:    start = 9'd212;
      4'd8:    start = 9'd243;
      4'd9:    start = 9'd273;
      4'd10:   start = 9'd304;
      4'd11:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

### design/rce_if.sv
// Beat interfaces for the RTC reading input and the converted time output.
interface rce_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] rtc_second;
  logic [6:0] rtc_minute;
  logic [6:0] rtc_hour;
  logic [6:0] rtc_day;
  logic [6:0] rtc_month;
  logic [6:0] rtc_year_low;
  logic [6:0] rtc_century;
  logic [2:0] rtc_weekday;

  modport source (
    output valid, rtc_second, rtc_minute, rtc_hour, rtc_day, rtc_month,
           rtc_year_low, rtc_century, rtc_weekday,
    input  ready
  );
  modport sink (
    input  valid, rtc_second, rtc_minute, rtc_hour, rtc_day, rtc_month,
           rtc_year_low, rtc_century, rtc_weekday,
    output ready
  );
endinterface

interface rce_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         norm_second;
  logic [5:0]         norm_minute;
  logic [4:0]         norm_hour;
  logic [4:0]         norm_day;
  logic [3:0]         month_index;
  logic signed [14:0] year_since_1900;
  logic [2:0]         weekday_index;
  logic [8:0]         day_of_year;
  logic [37:0]        epoch_seconds;
  logic               before_epoch;

  modport source (
    output valid, norm_second, norm_minute, norm_hour, norm_day, month_index,
           year_since_1900, weekday_index, day_of_year, epoch_seconds, before_epoch,
    input  ready
  );
  modport sink (
    input  valid, norm_second, norm_minute, norm_hour, norm_day, month_index,
           year_since_1900, weekday_index, day_of_year, epoch_seconds, before_epoch,
    output ready
  );
endinterface

### design/rce_pipe_ctl.sv
// Valid bits and per-stage load enables for the conversion pipeline.
module rce_pipe_ctl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output rce_pkg::pipe_ctl_t ctl_o
);

  logic [rce_pkg::NumStages-1:0] vld_q, vld_d, en;

  // A stage loads when it is empty or the stage after it moves on, so bubbles collapse.
  always_comb begin
    en[rce_pkg::NumStages-1] = !vld_q[rce_pkg::NumStages-1] || out_ready_i;
    for (int k = rce_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < rce_pkg::NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = en[0];
  assign ctl_o.vld  = vld_q;
  assign ctl_o.en   = en;

endmodule

### design/rtc_calendar_to_epoch_seconds.sv
// Top level: pipelined conversion of an RTC reading to normalized time and epoch seconds.
//
//   Channel  Dir  Beat content
//   in_i     in   rtc second, minute, hour, day, month, year low, century, weekday
//   out_o    out  normalized time, month, year - 1900, weekday, day of year, epoch seconds
//
// Six register stages; reset clears only the stage valid bits.
// A new reading is taken every cycle unless every stage is full and the output stalls;
// the 22 x 17 bit day-to-seconds multiply sets the depth of the fifth stage.
// A stall at the output holds the last full stage; earlier stages keep filling
// empty slots, so input ready drops only when every stage holds a beat.
module rtc_calendar_to_epoch_seconds (
  input  logic      clk_i,
  input  logic      rst_ni,
  rce_in_if.sink    in_i,
  rce_out_if.source out_o
);

  rce_pkg::pipe_ctl_t ctl;

  rce_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .ctl_o       (ctl)
  );

  // Stage 1: second carry, month carry, full year, weekday.
  logic [14:0] sec_prod, mon_prod;
  logic [1:0]  sec_car;
  logic [6:0]  mon0;
  logic [3:0]  mon_car;
  logic [5:0]  s1_sec_d, s1_sec_q;
  logic [7:0]  s1_min_d, s1_min_q;
  logic [6:0]  s1_hour_q, s1_day_q;
  logic [3:0]  s1_mon_d, s1_mon_q;
  logic [13:0] s1_year_d, s1_year_q;
  logic [2:0]  s1_wdi_d, s1_wdi_q;

  always_comb begin
    sec_prod = 15'(in_i.rtc_second) * 15'(rce_pkg::Div60Mul);
    sec_car  = 2'(sec_prod >> rce_pkg::Div60Shift);
    s1_sec_d = 6'(in_i.rtc_second - 7'(sec_car) * 7'(rce_pkg::SecPerMin));
    s1_min_d = 8'(in_i.rtc_minute) + 8'(sec_car);
    mon0     = (in_i.rtc_month == '0) ? '0 : in_i.rtc_month - 7'd1;
    mon_prod = 15'(mon0) * 15'(rce_pkg::Div12Mul);
    mon_car  = 4'(mon_prod >> rce_pkg::Div12Shift);
    s1_mon_d = 4'(mon0 - 7'(mon_car) * 7'(rce_pkg::MonPerYear));
    s1_year_d = 14'(in_i.rtc_century) * 14'(rce_pkg::YearsPerCentury)
              + 14'(in_i.rtc_year_low) + 14'(mon_car);
    s1_wdi_d = (in_i.rtc_weekday == '0) ? 3'd6 : in_i.rtc_weekday - 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      s1_sec_q  <= s1_sec_d;
      s1_min_q  <= s1_min_d;
      s1_hour_q <= in_i.rtc_hour;
      s1_day_q  <= in_i.rtc_day;
      s1_mon_q  <= s1_mon_d;
      s1_year_q <= s1_year_d;
      s1_wdi_q  <= s1_wdi_d;
    end
  end

  // Stage 2: minute carry, year / 100 for the leap test, century term of the epoch.
  logic [15:0] min_prod;
  logic [1:0]  min_car;
  logic [26:0] yr_prod, x69_prod;
  logic [13:0] x69;
  logic [5:0]  s2_sec_q, s2_min_d, s2_min_q;
  logic [7:0]  s2_hour_d, s2_hour_q;
  logic [6:0]  s2_day_q;
  logic [3:0]  s2_mon_q;
  logic [13:0] s2_year_q;
  logic [7:0]  s2_q100_d, s2_q100_q, s2_q69_d, s2_q69_q;
  logic        s2_before_d, s2_before_q;
  logic [2:0]  s2_wdi_q;

  always_comb begin
    min_prod  = 16'(s1_min_q) * 16'(rce_pkg::Div60Mul);
    min_car   = 2'(min_prod >> rce_pkg::Div60Shift);
    s2_min_d  = 6'(s1_min_q - 8'(min_car) * 8'(rce_pkg::MinPerHour));
    s2_hour_d = 8'(s1_hour_q) + 8'(min_car);
    yr_prod   = 27'(s1_year_q) * 27'(rce_pkg::Div100Mul);
    s2_q100_d = 8'(yr_prod >> rce_pkg::Div100Shift);
    // (y + 69) with y = year - 1970; the value is only used when the year is not early.
    x69       = s1_year_q - 14'(rce_pkg::EpochYear - 69);
    x69_prod  = 27'(x69) * 27'(rce_pkg::Div100Mul);
    s2_q69_d  = 8'(x69_prod >> rce_pkg::Div100Shift);
    s2_before_d = s1_year_q < 14'(rce_pkg::EpochYear);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[1]) begin
      s2_sec_q    <= s1_sec_q;
      s2_min_q    <= s2_min_d;
      s2_hour_q   <= s2_hour_d;
      s2_day_q    <= s1_day_q;
      s2_mon_q    <= s1_mon_q;
      s2_year_q   <= s1_year_q;
      s2_q100_q   <= s2_q100_d;
      s2_q69_q    <= s2_q69_d;
      s2_before_q <= s2_before_d;
      s2_wdi_q    <= s1_wdi_q;
    end
  end

  // Stage 3: hour carry into the day, leap year, days before the year.
  logic [15:0] hr_prod;
  logic [2:0]  hr_car;
  logic [6:0]  r100;
  logic [13:0] yrs;
  logic [5:0]  s3_sec_q, s3_min_q;
  logic [4:0]  s3_hour_d, s3_hour_q;
  logic [7:0]  s3_day_d, s3_day_q;
  logic [3:0]  s3_mon_q;
  logic [13:0] s3_year_q;
  logic        s3_leap_d, s3_leap_q, s3_before_q;
  logic [2:0]  s3_wdi_q;
  logic [21:0] s3_dpart_d, s3_dpart_q;

  always_comb begin
    hr_prod   = 16'(s2_hour_q) * 16'(rce_pkg::Div24Mul);
    hr_car    = 3'(hr_prod >> rce_pkg::Div24Shift);
    s3_hour_d = 5'(s2_hour_q - 8'(hr_car) * 8'(rce_pkg::HourPerDay));
    s3_day_d  = 8'(s2_day_q) + 8'(hr_car);
    r100      = 7'(s2_year_q - 14'(s2_q100_q) * 14'(rce_pkg::YearsPerCentury));
    s3_leap_d = (s2_year_q[1:0] == 2'b00 && r100 != '0)
             || (r100 == '0 && s2_q100_q[1:0] == 2'b00);
    yrs       = s2_year_q - 14'(rce_pkg::EpochYear);
    // The 400-year term is ((y + 69) / 100 + 3) / 4.
    s3_dpart_d = 22'(yrs) * 22'(rce_pkg::DayPerYear) + 22'((yrs + 14'd1) >> 2)
               - 22'(s2_q69_q) + 22'((9'(s2_q69_q) + 9'd3) >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[2]) begin
      s3_sec_q    <= s2_sec_q;
      s3_min_q    <= s2_min_q;
      s3_hour_q   <= s3_hour_d;
      s3_day_q    <= s3_day_d;
      s3_mon_q    <= s2_mon_q;
      s3_year_q   <= s2_year_q;
      s3_leap_q   <= s3_leap_d;
      s3_before_q <= s2_before_q;
      s3_wdi_q    <= s2_wdi_q;
      s3_dpart_q  <= s3_dpart_d;
    end
  end

  // Stage 4: clamp the day to the month length, day of year, seconds into the day.
  logic [7:0]  day2;
  logic [4:0]  mlen;
  logic [5:0]  s4_sec_q, s4_min_q;
  logic [4:0]  s4_hour_q, s4_day_d, s4_day_q;
  logic [3:0]  s4_mon_q;
  logic [13:0] s4_year_q;
  logic        s4_before_q;
  logic [2:0]  s4_wdi_q;
  logic [21:0] s4_dpart_q;
  logic [8:0]  s4_yday_d, s4_yday_q;
  logic [16:0] s4_tod_d, s4_tod_q;

  always_comb begin
    day2 = (s3_day_q == '0) ? 8'd1 : s3_day_q;
    mlen = (s3_mon_q == rce_pkg::MonFeb && s3_leap_q) ? 5'(rce_pkg::LeapDayFeb)
                                                    : rce_pkg::month_len(s3_mon_q);
    s4_day_d  = (day2 > 8'(mlen)) ? mlen : 5'(day2);
    s4_yday_d = rce_pkg::month_start(s3_mon_q) + 9'(s4_day_d) - 9'd1
              + 9'((s3_mon_q > rce_pkg::MonFeb) && s3_leap_q);
    s4_tod_d  = 17'(s3_hour_q) * 17'(rce_pkg::SecPerHour)
              + 17'(s3_min_q) * 17'(rce_pkg::SecPerMin) + 17'(s3_sec_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[3]) begin
      s4_sec_q    <= s3_sec_q;
      s4_min_q    <= s3_min_q;
      s4_hour_q   <= s3_hour_q;
      s4_day_q    <= s4_day_d;
      s4_mon_q    <= s3_mon_q;
      s4_year_q   <= s3_year_q;
      s4_before_q <= s3_before_q;
      s4_wdi_q    <= s3_wdi_q;
      s4_dpart_q  <= s3_dpart_q;
      s4_yday_q   <= s4_yday_d;
      s4_tod_q    <= s4_tod_d;
    end
  end

  // Stage 5: whole days times seconds per day.
  logic [21:0] days;
  logic [5:0]  s5_sec_q, s5_min_q;
  logic [4:0]  s5_hour_q, s5_day_q;
  logic [3:0]  s5_mon_q;
  logic [13:0] s5_year_q;
  logic        s5_before_q;
  logic [2:0]  s5_wdi_q;
  logic [8:0]  s5_yday_q;
  logic [16:0] s5_tod_q;
  logic [38:0] s5_prod_d, s5_prod_q;

  always_comb begin
    days      = s4_dpart_q + 22'(s4_yday_q);
    s5_prod_d = 39'(days) * 39'(rce_pkg::SecPerDay);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[4]) begin
      s5_sec_q    <= s4_sec_q;
      s5_min_q    <= s4_min_q;
      s5_hour_q   <= s4_hour_q;
      s5_day_q    <= s4_day_q;
      s5_mon_q    <= s4_mon_q;
      s5_year_q   <= s4_year_q;
      s5_before_q <= s4_before_q;
      s5_wdi_q    <= s4_wdi_q;
      s5_yday_q   <= s4_yday_q;
      s5_tod_q    <= s4_tod_q;
      s5_prod_q   <= s5_prod_d;
    end
  end

  // Stage 6: final sum with saturation, zero for early years, output register.
  logic [39:0] sum;
  logic [37:0] out_epoch_d, out_epoch_q;
  logic [14:0] out_ysig_d, out_ysig_q;
  logic [5:0]  out_sec_q, out_min_q;
  logic [4:0]  out_hour_q, out_day_q;
  logic [3:0]  out_mon_q;
  logic [2:0]  out_wdi_q;
  logic [8:0]  out_yday_q;
  logic        out_before_q;

  always_comb begin
    sum = 40'(s5_prod_q) + 40'(s5_tod_q);
    if (s5_before_q) begin
      out_epoch_d = '0;
    end else if (sum > 40'(rce_pkg::EpochMax)) begin
      out_epoch_d = rce_pkg::EpochMax;
    end else begin
      out_epoch_d = 38'(sum);
    end
    out_ysig_d = 15'(s5_year_q) - 15'(rce_pkg::BaseYear);
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en[5]) begin
      out_sec_q    <= s5_sec_q;
      out_min_q    <= s5_min_q;
      out_hour_q   <= s5_hour_q;
      out_day_q    <= s5_day_q;
      out_mon_q    <= s5_mon_q;
      out_ysig_q   <= out_ysig_d;
      out_wdi_q    <= s5_wdi_q;
      out_yday_q   <= s5_yday_q;
      out_epoch_q  <= out_epoch_d;
      out_before_q <= s5_before_q;
    end
  end

  assign out_o.valid           = ctl.vld[rce_pkg::NumStages-1];
  assign out_o.norm_second     = out_sec_q;
  assign out_o.norm_minute     = out_min_q;
  assign out_o.norm_hour       = out_hour_q;
  assign out_o.norm_day        = out_day_q;
  assign out_o.month_index     = out_mon_q;
  assign out_o.year_since_1900 = $signed(out_ysig_q);
  assign out_o.weekday_index   = out_wdi_q;
  assign out_o.day_of_year     = out_yday_q;
  assign out_o.epoch_seconds   = out_epoch_q;
  assign out_o.before_epoch    = out_before_q;

  a_early_year_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.before_epoch) |-> (out_o.epoch_seconds == '0))
    else $error("early year beat carries nonzero epoch seconds");

  a_flag_matches_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.before_epoch == (out_o.year_since_1900 < 15'sd70)))
    else $error("before_epoch disagrees with year_since_1900");

  a_day_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.norm_day != '0 && out_o.day_of_year <= 9'd365))
    else $error("day of month or day of year out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&ctl.vld) && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while every stage is full and stalled");

endmodule
